// ----- rtl/slt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and codes for the sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int KIND_W  = 2;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int OUT_W   = 48;

    localparam logic [KIND_W-1:0] KIND_INSERT     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE_ODD = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch the incoming request
        logic cmp;       // register per-entry compare flags
        logic apply;     // perform insert or remove shift
        logic odd_step;  // one step of the odd-removal rotation
        logic out_load;  // capture the result
    } t_slt_cmd;

    // datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              full;
        logic              empty;
        logic              odd_last;
    } t_slt_status;

endpackage

// ----- rtl/sorted_list_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_table_unit
// Bounded ascending table of signed 32-bit values with insert and removal.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis group: tuser carries the kind (insert,
//   remove one occurrence, remove all odd values), tdata the value.
//   Each request gives one result transaction on the m_axis group with the
//   success flag, the entry count, the smallest entry and an empty flag.
//   Entries live in a chain of CAPACITY registers kept in order; insert and
//   remove compare every cell against the value and shift the chain in the
//   cycle after the compare.
//   Insert and remove step through compare, shift and capture of the
//   result; an unused kind or an empty odd removal goes from compare
//   straight to capture; odd removal runs a rotation that pops one entry
//   per cycle through the chain, once for each held entry, before capture.
//   One request is in work at a time; a new request is accepted only
//   after the result of the current one is captured.
//   Reset empties the table and drops any pending result.
//   If the receiver stalls, the result waits in the output register; the
//   next request is still accepted and worked, then holds until the
//   register is taken.
// ----------------------------------------------------------------------------
module sorted_list_table_unit #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [0] ok, [7:1] count, [39:8] smallest,
                                        // [40] is_empty, [47:41] zero
);
    import slt_pkg::*;

    t_slt_cmd                  w_cmd;
    t_slt_status               w_status;
    logic                      w_ok;
    logic        [COUNT_W-1:0] w_count;
    logic signed [VALUE_W-1:0] w_smallest;
    logic                      w_is_empty;

    slt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    slt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_kind     (s_axis_tuser),
        .i_value    (s_axis_tdata),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_ok       (w_ok),
        .o_count    (w_count),
        .o_smallest (w_smallest),
        .o_is_empty (w_is_empty)
    );

    assign m_axis_tdata = {7'd0, w_is_empty, w_smallest, w_count, w_ok};

endmodule

// ----- rtl/slt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_ctrl
// Sequencer: accepts a request, steps the datapath, hands off the result.
// ----------------------------------------------------------------------------
module slt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    input  slt_pkg::t_slt_status i_status,
    output slt_pkg::t_slt_cmd    o_cmd
);
    import slt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMP   = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_ODD   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        n_out_valid    = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_status.kind inside {KIND_INSERT, KIND_REMOVE}) begin
                    n_state = S_APPLY;
                end else if (i_status.kind == KIND_REMOVE_ODD && !i_status.empty) begin
                    n_state = S_ODD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_FIN;
            end
            S_ODD: begin
                o_cmd.odd_step = 1'b1;
                if (i_status.odd_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/slt_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_datapath
// Sorted register chain with per-entry compare flags and shift control.
// ----------------------------------------------------------------------------
module slt_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [slt_pkg::KIND_W-1:0]   i_kind,
    input  logic signed [slt_pkg::VALUE_W-1:0] i_value,
    input  slt_pkg::t_slt_cmd            i_cmd,
    output slt_pkg::t_slt_status         o_status,
    output logic                         o_ok,
    output logic [slt_pkg::COUNT_W-1:0]  o_count,
    output logic signed [slt_pkg::VALUE_W-1:0] o_smallest,
    output logic                         o_is_empty
);
    import slt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [VALUE_W-1:0] r_entries [CAPACITY];
    logic signed [VALUE_W-1:0] n_entries [CAPACITY];
    logic        [CW-1:0]      r_count, n_count;
    logic        [CW-1:0]      r_steps;
    logic        [KIND_W-1:0]  r_kind;
    logic signed [VALUE_W-1:0] r_value;
    logic                      r_ok;
    logic        [CAPACITY-1:0] r_lt, r_match;
    logic        [CAPACITY-1:0] w_lt, w_lt_prev, w_match;
    logic                      w_full, w_empty, w_found, w_head_even;

    logic                      r_out_ok;
    logic        [COUNT_W-1:0] r_out_count;
    logic signed [VALUE_W-1:0] r_out_smallest;
    logic                      r_out_empty;

    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_found     = |r_match;
    assign w_head_even = !r_entries[0][0];

    // per-entry compare against the request value
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_lt[i] = (r_count > CW'(i)) && (r_entries[i] < r_value);
        end
        w_lt_prev[0] = 1'b1;
        for (int i = 1; i < CAPACITY; i++) begin
            w_lt_prev[i] = w_lt[i-1];
        end
        for (int i = 0; i < CAPACITY; i++) begin
            w_match[i] = (r_count > CW'(i)) && (r_entries[i] == r_value) && w_lt_prev[i];
        end
    end

    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        if (i_cmd.apply && r_kind == KIND_INSERT && !w_full) begin
            // the cell at the insert point takes the value; cells above it take their lower neighbor
            if (!r_lt[0]) begin
                n_entries[0] = r_value;
            end
            for (int i = 1; i < CAPACITY; i++) begin
                if (!r_lt[i]) begin
                    if (r_lt[i-1]) begin
                        n_entries[i] = r_value;
                    end else begin
                        n_entries[i] = r_entries[i-1];
                    end
                end
            end
            n_count = r_count + 1'b1;
        end else if (i_cmd.apply && r_kind == KIND_REMOVE && w_found) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (!r_lt[i]) begin
                    n_entries[i] = r_entries[i+1];
                end
            end
            n_count = r_count - 1'b1;
        end else if (i_cmd.odd_step) begin
            // pop the head; re-append it at the tail if even, drop it if odd
            for (int i = 0; i < CAPACITY - 1; i++) begin
                n_entries[i] = r_entries[i+1];
            end
            for (int i = 0; i < CAPACITY; i++) begin
                if (w_head_even && (CW'(i) == r_count - 1'b1)) begin
                    n_entries[i] = r_entries[0];
                end
            end
            if (!w_head_even) begin
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entries <= n_entries;
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
        if (i_cmd.cmp) begin
            r_lt    <= w_lt;
            r_match <= w_match;
            r_steps <= r_count;
            case (r_kind)
                KIND_INSERT:     r_ok <= !w_full;
                KIND_REMOVE_ODD: r_ok <= !w_empty;
                default:         r_ok <= 1'b0;
            endcase
        end
        if (i_cmd.apply && r_kind == KIND_REMOVE) begin
            r_ok <= w_found;
        end
        if (i_cmd.odd_step) begin
            r_steps <= r_steps - 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_ok       <= r_ok;
            r_out_count    <= COUNT_W'(r_count);
            r_out_smallest <= w_empty ? '0 : r_entries[0];
            r_out_empty    <= w_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_status.kind     = r_kind;
    assign o_status.full     = w_full;
    assign o_status.empty    = w_empty;
    assign o_status.odd_last = (r_steps == CW'(1));

    assign o_ok       = r_out_ok;
    assign o_count    = r_out_count;
    assign o_smallest = r_out_smallest;
    assign o_is_empty = r_out_empty;

endmodule
